// File: hw/rtl/dks_pkg.sv
// Shared constants and types of the dependent knapsack solver.
package dks_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DP_DEPTH  = 32768;

    localparam int PRICE_W  = 15;
    localparam int IMP_W    = 4;
    localparam int PARENT_W = 7;
    localparam int BUDGET_W = 15;
    localparam int TOTAL_W  = 32;

    localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int DP_AW   = $clog2(DP_DEPTH);
    localparam int SLOT_W  = PRICE_W + IMP_W;
    localparam int PG_W    = PRICE_W + IMP_W;
    localparam int COST_W  = PRICE_W + 2;
    localparam int GAIN_W  = PG_W + 2;
    localparam int NUM_OPT = 5;
    localparam int OPT_W   = $clog2(NUM_OPT);

    localparam logic [OPT_W-1:0] FIRST_OPT = OPT_W'(0);
    localparam logic [OPT_W-1:0] LAST_OPT  = OPT_W'(NUM_OPT - 1);

    typedef struct packed {
        logic               en;
        logic               is_main;
        logic [IDX_W-1:0]   idx;
        logic [PRICE_W-1:0] price;
        logic [IMP_W-1:0]   importance;
    } slot_wr_t;

    typedef struct packed {
        logic [2:0][PRICE_W-1:0] price;
        logic [2:0][IMP_W-1:0]   importance;
    } group_t;

    typedef struct packed {
        logic               en;
        logic [DP_AW-1:0]   addr;
        logic [TOTAL_W-1:0] data;
    } dp_wr_t;

endpackage

// File: hw/rtl/dks_item_store.sv
// Item slot memories (main, first and second attachment per group) with valid bits.
module dks_item_store
    import dks_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  slot_wr_t         wr,
    input  logic             clear,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output group_t           rd_group
);

    logic [SLOT_W-1:0] main_mem [MAX_ITEMS];
    logic [SLOT_W-1:0] att1_mem [MAX_ITEMS];
    logic [SLOT_W-1:0] att2_mem [MAX_ITEMS];

    logic [MAX_ITEMS-1:0] main_vld_reg, main_vld_next;
    logic [MAX_ITEMS-1:0] att1_vld_reg, att1_vld_next;
    logic [MAX_ITEMS-1:0] att2_vld_reg, att2_vld_next;

    logic [SLOT_W-1:0] main_q_reg, att1_q_reg, att2_q_reg;
    logic [2:0]        rd_vld_reg, rd_vld_next;

    logic wr_main, wr_att1, wr_att2;

    // The first attachment of a group fills slot one; any later one fills slot two.
    assign wr_main = wr.en && wr.is_main;
    assign wr_att1 = wr.en && !wr.is_main && !att1_vld_reg[wr.idx];
    assign wr_att2 = wr.en && !wr.is_main && att1_vld_reg[wr.idx];

    always_comb
    begin
        main_vld_next = main_vld_reg;
        att1_vld_next = att1_vld_reg;
        att2_vld_next = att2_vld_reg;
        if (clear)
        begin
            main_vld_next = '0;
            att1_vld_next = '0;
            att2_vld_next = '0;
        end
        else
        begin
            if (wr_main)
            begin
                main_vld_next[wr.idx] = 1'b1;
            end
            if (wr_att1)
            begin
                att1_vld_next[wr.idx] = 1'b1;
            end
            if (wr_att2)
            begin
                att2_vld_next[wr.idx] = 1'b1;
            end
        end
        rd_vld_next = rd_vld_reg;
        if (rd_en)
        begin
            rd_vld_next = {att2_vld_reg[rd_idx], att1_vld_reg[rd_idx], main_vld_reg[rd_idx]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= '0;
            att1_vld_reg <= '0;
            att2_vld_reg <= '0;
            rd_vld_reg   <= '0;
        end
        else
        begin
            main_vld_reg <= main_vld_next;
            att1_vld_reg <= att1_vld_next;
            att2_vld_reg <= att2_vld_next;
            rd_vld_reg   <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_main)
        begin
            main_mem[wr.idx] <= {wr.price, wr.importance};
        end
        if (wr_att1)
        begin
            att1_mem[wr.idx] <= {wr.price, wr.importance};
        end
        if (wr_att2)
        begin
            att2_mem[wr.idx] <= {wr.price, wr.importance};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            main_q_reg <= main_mem[rd_idx];
            att1_q_reg <= att1_mem[rd_idx];
            att2_q_reg <= att2_mem[rd_idx];
        end
    end

    assign rd_group.price[0]      = rd_vld_reg[0] ? main_q_reg[SLOT_W-1:IMP_W] : '0;
    assign rd_group.price[1]      = rd_vld_reg[1] ? att1_q_reg[SLOT_W-1:IMP_W] : '0;
    assign rd_group.price[2]      = rd_vld_reg[2] ? att2_q_reg[SLOT_W-1:IMP_W] : '0;
    assign rd_group.importance[0] = rd_vld_reg[0] ? main_q_reg[IMP_W-1:0] : '0;
    assign rd_group.importance[1] = rd_vld_reg[1] ? att1_q_reg[IMP_W-1:0] : '0;
    assign rd_group.importance[2] = rd_vld_reg[2] ? att2_q_reg[IMP_W-1:0] : '0;

endmodule

// File: hw/rtl/dks_dp_ram.sv
// Best-total-by-budget memory with one write port and one registered read port.
module dks_dp_ram
    import dks_pkg::*;
(
    input  logic               clk,
    input  dp_wr_t             wr,
    input  logic               rd_en,
    input  logic [DP_AW-1:0]   rd_addr,
    output logic [TOTAL_W-1:0] rd_data
);

    logic [TOTAL_W-1:0] mem [DP_DEPTH];
    logic [TOTAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/dependent_knapsack_solver_unit.sv
// Dependent knapsack solver: item loading, DP sequencer and result register.
// Loading accepts one item transaction per cycle while in_stall is low.
// The solve after the last item clears DP entries 0 to n, n being the budget limited to DP_DEPTH - 1,
// then walks every group over those entries from n down to 0: the DP memory has one read
// port, so each budget entry needs five reads per group. No item is accepted during a solve.
// Reset (rst_n, asynchronous) empties all slots and the item count and sets the budget to 0.
module dependent_knapsack_solver_unit
    import dks_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [BUDGET_W-1:0] budget,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PRICE_W-1:0]  price,
    input  logic [IMP_W-1:0]    importance,
    input  logic [PARENT_W-1:0] parent,
    input  logic                last_item,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TOTAL_W-1:0]  best_total
);

    typedef enum logic [8:0] {
        S_LOAD   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_FETCH  = 9'b000000100,
        S_PREP1  = 9'b000001000,
        S_PREP2  = 9'b000010000,
        S_WALK   = 9'b000100000,
        S_DRAIN  = 9'b001000000,
        S_READ   = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [GAIN_W-1:0]  b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [DP_AW-1:0]    n_reg, n_next;
    logic [DP_AW-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]    g_reg, g_next;
    logic [OPT_W-1:0]    k_reg, k_next;

    logic [2:0][PRICE_W-1:0]        c_reg, c_next;
    logic [2:0][PG_W-1:0]           w_reg, w_next;
    logic [NUM_OPT-1:0][COST_W-1:0] cost_reg, cost_next;
    logic [NUM_OPT-1:0][GAIN_W-1:0] gain_reg, gain_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_ok_reg, s1_ok_next;
    logic [OPT_W-1:0]   s1_k_reg, s1_k_next;
    logic [DP_AW-1:0]   s1_j_reg, s1_j_next;
    logic [GAIN_W-1:0]  s1_gain_reg, s1_gain_next;
    logic               sa_valid_reg, sa_valid_next;
    logic [OPT_W-1:0]   sa_k_reg, sa_k_next;
    logic [DP_AW-1:0]   sa_j_reg, sa_j_next;
    logic [TOTAL_W-1:0] sa_cand_reg, sa_cand_next;
    logic [TOTAL_W-1:0] acc_reg, acc_next;

    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] out_data_reg, out_data_next;

    logic               in_accept;
    logic [IDX_W-1:0]   parent_m1;
    logic [DP_AW-1:0]   budget_sat;
    logic [TOTAL_W-1:0] cand_max;
    logic               pipe_wr;
    logic               clear_wr;

    slot_wr_t           slot_wr;
    logic               items_clear;
    logic               slot_rd_en;
    group_t             grp;
    dp_wr_t             dp_wr;
    logic               dp_rd_en;
    logic [DP_AW-1:0]   dp_rd_addr;
    logic [TOTAL_W-1:0] dp_rd_data;

    dks_item_store u_item_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (slot_wr),
        .clear    (items_clear),
        .rd_en    (slot_rd_en),
        .rd_idx   (g_reg),
        .rd_group (grp)
    );

    dks_dp_ram u_dp_ram (
        .clk     (clk),
        .wr      (dp_wr),
        .rd_en   (dp_rd_en),
        .rd_addr (dp_rd_addr),
        .rd_data (dp_rd_data)
    );

    assign in_stall   = (state_reg != S_LOAD);
    assign in_accept  = in_valid && !in_stall;
    assign parent_m1  = IDX_W'(32'(parent) - 32'd1);
    assign budget_sat = (32'(budget_reg) > 32'(DP_DEPTH - 1)) ? DP_AW'(DP_DEPTH - 1)
                                                              : DP_AW'(budget_reg);
    assign budget_next = cfg_wr_en ? budget : budget_reg;

    // Candidates reaching the last stage fold into a running maximum for one budget entry.
    assign cand_max = (sa_k_reg == FIRST_OPT || sa_cand_reg > acc_reg) ? sa_cand_reg : acc_reg;
    assign pipe_wr  = sa_valid_reg && (sa_k_reg == LAST_OPT);
    assign clear_wr = (state_reg == S_CLEAR);

    assign dp_wr.en   = clear_wr || pipe_wr;
    assign dp_wr.addr = clear_wr ? addr_reg : sa_j_reg;
    assign dp_wr.data = clear_wr ? '0 : cand_max;

    assign acc_next      = sa_valid_reg ? cand_max : acc_reg;
    assign sa_valid_next = s1_valid_reg;
    assign sa_k_next     = s1_k_reg;
    assign sa_j_next     = s1_j_reg;
    assign sa_cand_next  = s1_ok_reg ? sat_add(dp_rd_data, s1_gain_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        addr_next      = addr_reg;
        g_next         = g_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        w_next         = w_reg;
        cost_next      = cost_reg;
        gain_next      = gain_reg;
        s1_valid_next  = 1'b0;
        s1_ok_next     = s1_ok_reg;
        s1_k_next      = s1_k_reg;
        s1_j_next      = s1_j_reg;
        s1_gain_next   = s1_gain_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        slot_wr        = '0;
        items_clear    = 1'b0;
        slot_rd_en     = 1'b0;
        dp_rd_en       = 1'b0;
        dp_rd_addr     = addr_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (32'(count_reg) < 32'(MAX_ITEMS))
                    begin
                        count_next         = count_reg + CNT_W'(1);
                        slot_wr.price      = price;
                        slot_wr.importance = importance;
                        if (parent == '0)
                        begin
                            slot_wr.en      = 1'b1;
                            slot_wr.is_main = 1'b1;
                            slot_wr.idx     = count_reg[IDX_W-1:0];
                        end
                        else if (32'(parent) <= 32'(MAX_ITEMS))
                        begin
                            slot_wr.en  = 1'b1;
                            slot_wr.idx = parent_m1;
                        end
                    end
                    if (last_item)
                    begin
                        n_next     = budget_sat;
                        addr_next  = '0;
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                if (addr_reg == n_reg)
                begin
                    g_next     = '0;
                    state_next = (count_reg == '0) ? S_READ : S_FETCH;
                end
                else
                begin
                    addr_next = addr_reg + DP_AW'(1);
                end
            end
            S_FETCH:
            begin
                slot_rd_en = 1'b1;
                state_next = S_PREP1;
            end
            S_PREP1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c_next[i] = grp.price[i];
                    w_next[i] = PG_W'(grp.price[i]) * PG_W'(grp.importance[i]);
                end
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                // Option zero reads the entry itself; the others are the four group choices.
                cost_next[0] = '0;
                gain_next[0] = '0;
                cost_next[1] = COST_W'(c_reg[0]);
                gain_next[1] = GAIN_W'(w_reg[0]);
                cost_next[2] = COST_W'(c_reg[0]) + COST_W'(c_reg[1]);
                gain_next[2] = GAIN_W'(w_reg[0]) + GAIN_W'(w_reg[1]);
                cost_next[3] = COST_W'(c_reg[0]) + COST_W'(c_reg[2]);
                gain_next[3] = GAIN_W'(w_reg[0]) + GAIN_W'(w_reg[2]);
                cost_next[4] = COST_W'(c_reg[0]) + COST_W'(c_reg[1]) + COST_W'(c_reg[2]);
                gain_next[4] = GAIN_W'(w_reg[0]) + GAIN_W'(w_reg[1]) + GAIN_W'(w_reg[2]);
                addr_next    = n_reg;
                k_next       = FIRST_OPT;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                dp_rd_en      = 1'b1;
                dp_rd_addr    = DP_AW'(32'(addr_reg) - 32'(cost_reg[k_reg]));
                s1_valid_next = 1'b1;
                s1_ok_next    = (32'(addr_reg) >= 32'(cost_reg[k_reg]));
                s1_k_next     = k_reg;
                s1_j_next     = addr_reg;
                s1_gain_next  = gain_reg[k_reg];
                if (k_reg == LAST_OPT)
                begin
                    k_next = FIRST_OPT;
                    if (addr_reg == '0)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        addr_next = addr_reg - DP_AW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + OPT_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!s1_valid_reg && !sa_valid_reg)
                begin
                    if (CNT_W'(g_reg) + CNT_W'(1) == count_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        g_next     = g_reg + IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            S_READ:
            begin
                dp_rd_en   = 1'b1;
                dp_rd_addr = n_reg;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = dp_rd_data;
                    items_clear    = 1'b1;
                    count_next     = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            budget_reg    <= '0;
            g_reg         <= '0;
            k_reg         <= '0;
            addr_reg      <= '0;
            n_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            sa_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            budget_reg    <= budget_next;
            g_reg         <= g_next;
            k_reg         <= k_next;
            addr_reg      <= addr_next;
            n_reg         <= n_next;
            s1_valid_reg  <= s1_valid_next;
            sa_valid_reg  <= sa_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        w_reg        <= w_next;
        cost_reg     <= cost_next;
        gain_reg     <= gain_next;
        s1_ok_reg    <= s1_ok_next;
        s1_k_reg     <= s1_k_next;
        s1_j_reg     <= s1_j_next;
        s1_gain_reg  <= s1_gain_next;
        sa_k_reg     <= sa_k_next;
        sa_j_reg     <= sa_j_next;
        sa_cand_reg  <= sa_cand_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_total = out_data_reg;

endmodule

// File: test/dependent_knapsack_solver_unit_tb.sv
// Self-checking testbench for the dependent knapsack solver with bursty loads and output stalls.
`timescale 1ns / 1ps

module dependent_knapsack_solver_unit_tb;
    import dks_pkg::*;

    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic [IMP_W-1:0]    importance;
        logic [PARENT_W-1:0] parent;
        logic                last_flag;
    } load_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [BUDGET_W-1:0] budget = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [PRICE_W-1:0]  price = '0;
    logic [IMP_W-1:0]    importance = '0;
    logic [PARENT_W-1:0] parent = '0;
    logic                last_item = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [TOTAL_W-1:0]  best_total;

    load_item_t         pending_items[$];
    logic [TOTAL_W-1:0] expected_totals[$];
    load_item_t         next_item;
    logic [TOTAL_W-1:0] want_total;

    logic [PRICE_W-1:0] grp_price [3][MAX_ITEMS];
    logic [IMP_W-1:0]   grp_imp [3][MAX_ITEMS];
    int unsigned        grp_attach [MAX_ITEMS];
    int unsigned        loaded_count = 0;
    int unsigned        model_budget = 0;
    logic [TOTAL_W-1:0] best_at [DP_DEPTH];

    int unsigned errors = 0;
    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned widest_budget = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;

    dependent_knapsack_solver_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .budget    (budget),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .price     (price),
        .importance(importance),
        .parent    (parent),
        .last_item (last_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .best_total(best_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void relax(input int unsigned j, input int unsigned cost,
                                  input longint unsigned gain);
        longint unsigned cand;
        if (j >= cost)
        begin
            cand = 64'(best_at[j - cost]) + gain;
            if (cand > 64'hFFFF_FFFF)
                cand = 64'hFFFF_FFFF;
            if (cand > 64'(best_at[j]))
                best_at[j] = cand[TOTAL_W-1:0];
        end
    endfunction

    function automatic logic [TOTAL_W-1:0] knapsack_best();
        int unsigned     n;
        int unsigned     c [3];
        longint unsigned w [3];
        n = model_budget;
        if (n > DP_DEPTH - 1)
            n = DP_DEPTH - 1;
        for (int unsigned j = 0; j <= n; j++)
            best_at[j] = '0;
        for (int unsigned g = 0; g < loaded_count; g++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                c[s] = 32'(grp_price[s][g]);
                w[s] = 64'(c[s]) * 64'(grp_imp[s][g]);
            end
            for (int unsigned j = n + 1; j > 0; j--)
            begin
                relax(j - 1, c[0], w[0]);
                relax(j - 1, c[0] + c[1], w[0] + w[1]);
                relax(j - 1, c[0] + c[2], w[0] + w[2]);
                relax(j - 1, c[0] + c[1] + c[2], w[0] + w[1] + w[2]);
            end
        end
        return best_at[n];
    endfunction

    function automatic void load_item(input logic [PRICE_W-1:0] p, input logic [IMP_W-1:0] w,
                                      input logic [PARENT_W-1:0] par, input logic fin);
        int unsigned g;
        int unsigned s;
        if (loaded_count < MAX_ITEMS)
        begin
            g = loaded_count;
            loaded_count++;
            if (par == 0)
            begin
                grp_price[0][g] = p;
                grp_imp[0][g] = w;
            end
            else if (par <= MAX_ITEMS)
            begin
                g = par - 1;
                s = (grp_attach[g] == 0) ? 1 : 2;
                if (grp_attach[g] < 2)
                    grp_attach[g]++;
                grp_price[s][g] = p;
                grp_imp[s][g] = w;
            end
        end
        if (fin)
        begin
            expected_totals.push_back(knapsack_best());
            for (int k = 0; k < MAX_ITEMS; k++)
            begin
                for (int t = 0; t < 3; t++)
                begin
                    grp_price[t][k] = '0;
                    grp_imp[t][k] = '0;
                end
                grp_attach[k] = 0;
            end
            loaded_count = 0;
        end
    endfunction

    function automatic void add_item(input int unsigned p, input int unsigned w,
                                     input int unsigned par, input bit fin);
        load_item_t it;
        it.price = PRICE_W'(p);
        it.importance = IMP_W'(w);
        it.parent = PARENT_W'(par);
        it.last_flag = fin;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void queue_pass(input int unsigned count, input int unsigned price_cap);
        int unsigned att_seen [128];
        int unsigned mains[$];
        int unsigned roll;
        int unsigned pick;
        int unsigned par;
        int unsigned p;
        for (int unsigned k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                par = $urandom_range(0, 127);
            else if (mains.size() == 0 || roll < 50)
                par = 0;
            else
            begin
                pick = mains[$urandom_range(0, mains.size() - 1)];
                if (att_seen[pick] >= 2 && roll < 90)
                    par = 0;
                else
                    par = pick;
            end
            if (par == 0)
                mains.push_back(k + 1);
            else if (par < 128)
                att_seen[par]++;
            if ($urandom_range(0, 9) == 0)
                p = $urandom_range(0, 32767);
            else
                p = $urandom_range(0, price_cap);
            add_item(p, $urandom_range(0, 15), par, k == count - 1);
        end
    endfunction

    task automatic write_budget(input int unsigned v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        budget <= BUDGET_W'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_budget = v;
        if (v > widest_budget)
            widest_budget = v;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_totals.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    // Sender: bursts of transactions separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                load_item(price, importance, parent, last_item);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    price <= next_item.price;
                    importance <= next_item.importance;
                    parent <= next_item.parent;
                    last_item <= next_item.last_flag;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction and stalls in changing modes.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_totals.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: best_total=%0d", best_total);
                end
                else
                begin
                    want_total = expected_totals.pop_front();
                    if (best_total !== want_total)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch on result %0d: expected best_total=%0d, got %0d",
                                     results_seen, want_total, best_total);
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_left = $urandom_range(1, 40);
                stall_mode = $urandom_range(0, 3);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= 1'b1;
            endcase
        end
    end

    initial
    begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned b;
        int unsigned roll;
        int unsigned count;
        int unsigned phase_items;
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            for (int t = 0; t < 3; t++)
            begin
                grp_price[t][k] = '0;
                grp_imp[t][k] = '0;
            end
            grp_attach[k] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_budget(50);
        add_item(10, 3, 0, 0);
        add_item(5, 2, 1, 0);
        add_item(7, 4, 1, 0);
        add_item(3, 15, 1, 0);
        add_item(20, 1, 0, 0);
        add_item(0, 0, 5, 0);
        add_item(4, 9, 5, 0);
        add_item(6, 7, 2, 0);
        add_item(8, 8, 100, 0);
        add_item(9, 9, 64, 0);
        add_item(32767, 15, 0, 1);
        add_item(0, 0, 0, 1);
        add_item(1, 15, 0, 1);
        wait_idle();

        write_budget(32767);
        add_item(32767, 15, 0, 1);
        wait_idle();

        write_budget(0);
        add_item(0, 15, 0, 0);
        add_item(0, 15, 1, 0);
        add_item(5, 3, 0, 1);
        wait_idle();

        while (items_queued < 740)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                b = 0;
            else if (roll < 7)
                b = $urandom_range(1, 100);
            else
                b = $urandom_range(101, 300);
            write_budget(b);
            phase_items = 0;
            while (phase_items < 60 && items_queued < 740)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5 && b <= 100)
                    count = $urandom_range(65, 80);
                else if (roll < 15)
                    count = $urandom_range(13, 30);
                else
                    count = $urandom_range(1, 10);
                queue_pass(count, b / 2 + 1);
                phase_items += count;
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("run covered %0d item transactions and %0d checked solves, budgets 0 to %0d",
                 items_accepted, results_seen, widest_budget);
        $display("mismatches and unexpected results: %0d", errors);
        if (errors == 0 && expected_totals.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
